>>> rtl/complex_arithmetic_unit_core_defines.svh
// Assertion macros used by cau_back.
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CAU_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");
`define CAU_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define CAU_ASSERT_IMP(label, clk, rst, cond, prop)
`define CAU_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

>>> rtl/cau_pkg.sv
`timescale 1ns / 1ps
package cau_pkg;

   localparam int DATA_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int SHIFT_W     = DATA_W - FRAC_W;
   localparam int DIV_STEPS   = DATA_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int TOL_W       = 31;
   localparam logic [TOL_W-1:0] TOL_RESET = 31'd655;

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_MUL   = 3'd2,
      OP_DIV   = 3'd3,
      OP_SDIV  = 3'd4,
      OP_CONJ  = 3'd5,
      OP_MOD   = 3'd6,
      OP_EQUAL = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_SAT      = 2'd2
   } status_type;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef struct packed {
      op_type              op;
      word_type            a_re;
      word_type            a_im;
      word_type            b_re;
      word_type            b_im;
      logic                div_zero;
      logic                br_neg;
      logic [DATA_W-1:0]   br_mag;
   } item_type;

   typedef struct packed {
      op_type op;
      logic   div_zero;
      logic   br_neg;
   } ctl_type;

   typedef struct packed {
      word_type re;
      word_type im;
      logic     sat;
      logic     eq;
   } pass_type;

   // one divider lane: partial remainder, numerator bits still to shift in, quotient
   typedef struct packed {
      logic              neg;
      logic              ovf;
      logic [PROD_W-1:0] rem;
      logic [DATA_W-1:0] nb;
      logic [DATA_W-1:0] quo;
   } lane_type;

   typedef struct packed {
      word_type value;
      logic     sat;
   } fin_type;

   function automatic fin_type saturate(input logic neg, input logic [PROD_W-1:0] mag);
      logic [PROD_W-1:0] lim;
      logic [PROD_W-1:0] m;
      fin_type f;
      lim = neg ? (PROD_W'(1) << (DATA_W - 1))
                : ((PROD_W'(1) << (DATA_W - 1)) - PROD_W'(1));
      f.sat = mag > lim;
      m = f.sat ? lim : mag;
      f.value = neg ? -m[DATA_W-1:0] : m[DATA_W-1:0];
      return f;
   endfunction

   // one restoring step, one quotient bit
   function automatic lane_type div_step(input lane_type l, input logic [PROD_W-1:0] den);
      logic [PROD_W:0] t;
      lane_type o;
      o = l;
      t = {l.rem, l.nb[DATA_W-1]};
      if (t >= {1'b0, den}) begin
         t = t - {1'b0, den};
         o.quo = {l.quo[DATA_W-2:0], 1'b1};
      end else begin
         o.quo = {l.quo[DATA_W-2:0], 1'b0};
      end
      o.rem = t[PROD_W-1:0];
      o.nb = {l.nb[DATA_W-2:0], 1'b0};
      return o;
   endfunction

endpackage

>>> rtl/cau_front.sv
`timescale 1ns / 1ps
module cau_front import cau_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_push,
   output logic                     in_full,
   input  logic [2:0]               in_operation,
   input  logic signed [DATA_W-1:0] in_a_re,
   input  logic signed [DATA_W-1:0] in_a_im,
   input  logic signed [DATA_W-1:0] in_b_re,
   input  logic signed [DATA_W-1:0] in_b_im,
   output logic                     q_push,
   output item_type                 q_item,
   input  logic                     q_full
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;
   logic     br_zero, bi_zero;

   assign q_push  = valid_ff && !q_full;
   assign in_full = valid_ff && q_full;
   assign accept  = in_push && !in_full;
   assign q_item  = item_ff;

   always_comb begin
      br_zero = in_b_re == '0;
      bi_zero = in_b_im == '0;
      item_in.op     = op_type'(in_operation);
      item_in.a_re   = in_a_re;
      item_in.a_im   = in_a_im;
      item_in.b_re   = in_b_re;
      item_in.b_im   = in_b_im;
      item_in.br_neg = in_b_re[DATA_W-1];
      item_in.br_mag = in_b_re[DATA_W-1] ? -in_b_re : in_b_re;
      case (item_in.op)
         OP_DIV:  item_in.div_zero = br_zero && bi_zero;
         OP_SDIV: item_in.div_zero = br_zero;
         default: item_in.div_zero = 1'b0;
      endcase
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

>>> rtl/cau_queue.sv
`timescale 1ns / 1ps
module cau_queue import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type pop_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type   mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full     = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/cau_back.sv
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_core_defines.svh"
module cau_back import cau_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  item_type           q_item,
   output logic               q_pop,
   input  logic [TOL_W-1:0]   tolerance,
   output logic               out_empty,
   input  logic               out_pop,
   output logic [DATA_W-1:0]  out_res_re,
   output logic [DATA_W-1:0]  out_res_im,
   output logic               out_is_equal,
   output logic [1:0]         out_status
);

   typedef struct packed {
      ctl_type                      ctl;
      logic [5:0][PROD_W-1:0]       p;
      logic signed [DATA_W:0]       d_re;
      logic signed [DATA_W:0]       d_im;
      word_type                     a_re;
      word_type                     a_im;
      logic [DATA_W-1:0]            br_mag;
   } s1_type;

   typedef struct packed {
      ctl_type                ctl;
      logic signed [PROD_W:0] s_re;
      logic signed [PROD_W:0] s_im;
      logic [PROD_W-1:0]      den;
      pass_type               pass;
      logic [DATA_W:0]        dr;
      logic [DATA_W:0]        di;
   } s2_type;

   typedef struct packed {
      ctl_type           ctl;
      pass_type          pass;
      logic              neg_re;
      logic [PROD_W-1:0] mag_re;
      logic              neg_im;
      logic [PROD_W-1:0] mag_im;
      logic [PROD_W-1:0] den;
   } s3_type;

   typedef struct packed {
      ctl_type                  ctl;
      pass_type                 pass;
      logic [PROD_W-1:0]        den;
      lane_type                 lre;
      lane_type                 lim;
      logic [PROD_W-FRAC_W:0]   m_re;
      logic [PROD_W-FRAC_W:0]   m_im;
   } s4_type;

   typedef struct packed {
      ctl_type           ctl;
      pass_type          pass;
      lane_type          lre;
      lane_type          lim;
      logic [PROD_W-1:0] den;
   } dst_type;

   typedef struct packed {
      word_type   re;
      word_type   im;
      logic       eq;
      status_type st;
   } fo_type;

   localparam logic [PROD_W:0] ROUND = (PROD_W + 1)'((1 << FRAC_W) - 1);

   logic en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, fo_valid_ff;
   logic [DIV_STEPS:0] dv_ff;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3_type  s3_ff, s3_in;
   s4_type  s4_ff, s4_in;
   dst_type dst_ff [DIV_STEPS+1];
   dst_type dst_in [DIV_STEPS+1];
   fo_type  fo_ff, fo_in;

   logic signed [DATA_W-1:0] my0, my1;
   logic [DATA_W:0]          mr, mi;
   fin_type                  fr, fi;
   logic [PROD_W:0]          ar_abs, ai_abs, tr, ti;
   fin_type                  sr, si, qr, qi;
   dst_type                  dl;

   // whole back pipe advances together when the output slot frees up
   assign en    = !fo_valid_ff || out_pop;
   assign q_pop = en && !q_empty;

   // multiplier stage
   always_comb begin
      my0 = (q_item.op == OP_MOD) ? q_item.a_re : q_item.b_re;
      my1 = (q_item.op == OP_MOD) ? q_item.a_im : q_item.b_im;
      s1_in.ctl.op       = q_item.op;
      s1_in.ctl.div_zero = q_item.div_zero;
      s1_in.ctl.br_neg   = q_item.br_neg;
      s1_in.p[0] = $signed(q_item.a_re) * $signed(my0);
      s1_in.p[1] = $signed(q_item.a_im) * $signed(my1);
      s1_in.p[2] = $signed(q_item.a_re) * $signed(q_item.b_im);
      s1_in.p[3] = $signed(q_item.a_im) * $signed(q_item.b_re);
      s1_in.p[4] = $signed(q_item.b_re) * $signed(q_item.b_re);
      s1_in.p[5] = $signed(q_item.b_im) * $signed(q_item.b_im);
      case (q_item.op)
         OP_ADD: begin
            s1_in.d_re = $signed(q_item.a_re) + $signed(q_item.b_re);
            s1_in.d_im = $signed(q_item.a_im) + $signed(q_item.b_im);
         end
         OP_CONJ: begin
            s1_in.d_re = $signed(q_item.a_re);
            s1_in.d_im = -$signed({q_item.a_im[DATA_W-1], q_item.a_im});
         end
         default: begin
            s1_in.d_re = $signed(q_item.a_re) - $signed(q_item.b_re);
            s1_in.d_im = $signed(q_item.a_im) - $signed(q_item.b_im);
         end
      endcase
      s1_in.a_re   = q_item.a_re;
      s1_in.a_im   = q_item.a_im;
      s1_in.br_mag = q_item.br_mag;
   end

   // sums of products, add/sub/conjugate saturation
   always_comb begin
      s2_in.ctl = s1_ff.ctl;
      mr = s1_ff.d_re[DATA_W] ? (~s1_ff.d_re + 1'b1) : s1_ff.d_re;
      mi = s1_ff.d_im[DATA_W] ? (~s1_ff.d_im + 1'b1) : s1_ff.d_im;
      fr = saturate(s1_ff.d_re[DATA_W], PROD_W'(mr));
      fi = saturate(s1_ff.d_im[DATA_W], PROD_W'(mi));
      s2_in.dr = mr;
      s2_in.di = mi;
      s2_in.s_re = '0;
      s2_in.s_im = '0;
      s2_in.den  = '0;
      s2_in.pass = '0;
      case (s1_ff.ctl.op)
         OP_MUL: begin
            s2_in.s_re = $signed(s1_ff.p[0]) - $signed(s1_ff.p[1]);
            s2_in.s_im = $signed(s1_ff.p[2]) + $signed(s1_ff.p[3]);
         end
         OP_DIV: begin
            s2_in.s_re = $signed(s1_ff.p[0]) + $signed(s1_ff.p[1]);
            s2_in.s_im = $signed(s1_ff.p[3]) - $signed(s1_ff.p[2]);
            s2_in.den  = s1_ff.p[4] + s1_ff.p[5];
         end
         OP_MOD: begin
            s2_in.s_re = $signed(s1_ff.p[0]) + $signed(s1_ff.p[1]);
         end
         OP_SDIV: begin
            s2_in.s_re = $signed(s1_ff.a_re);
            s2_in.s_im = $signed(s1_ff.a_im);
            s2_in.den  = PROD_W'(s1_ff.br_mag);
         end
         OP_ADD, OP_SUB, OP_CONJ: begin
            s2_in.pass.re  = fr.value;
            s2_in.pass.im  = fi.value;
            s2_in.pass.sat = fr.sat || fi.sat;
         end
         default: begin
         end
      endcase
   end

   // sign and magnitude, tolerance compare
   always_comb begin
      ar_abs = s2_ff.s_re[PROD_W] ? (~s2_ff.s_re + 1'b1) : s2_ff.s_re;
      ai_abs = s2_ff.s_im[PROD_W] ? (~s2_ff.s_im + 1'b1) : s2_ff.s_im;
      s3_in.ctl    = s2_ff.ctl;
      s3_in.pass   = s2_ff.pass;
      s3_in.den    = s2_ff.den;
      s3_in.mag_re = ar_abs[PROD_W-1:0];
      s3_in.mag_im = ai_abs[PROD_W-1:0];
      s3_in.neg_re = s2_ff.s_re[PROD_W];
      s3_in.neg_im = s2_ff.s_im[PROD_W];
      if (s2_ff.ctl.op == OP_SDIV) begin
         s3_in.neg_re = s2_ff.s_re[PROD_W] ^ s2_ff.ctl.br_neg;
         s3_in.neg_im = s2_ff.s_im[PROD_W] ^ s2_ff.ctl.br_neg;
      end
      if (s2_ff.ctl.op == OP_EQUAL) begin
         s3_in.pass.eq = (s2_ff.dr <= (DATA_W + 1)'(tolerance))
                      && (s2_ff.di <= (DATA_W + 1)'(tolerance));
      end
   end

   // product scaling (floor), divider setup and overflow check
   always_comb begin
      tr = {1'b0, s3_ff.mag_re} + (s3_ff.neg_re ? ROUND : '0);
      ti = {1'b0, s3_ff.mag_im} + (s3_ff.neg_im ? ROUND : '0);
      s4_in.ctl  = s3_ff.ctl;
      s4_in.pass = s3_ff.pass;
      s4_in.den  = s3_ff.den;
      s4_in.m_re = tr[PROD_W:FRAC_W];
      s4_in.m_im = ti[PROD_W:FRAC_W];
      s4_in.lre.neg = s3_ff.neg_re;
      s4_in.lre.ovf = PROD_W'(s3_ff.mag_re[PROD_W-1:SHIFT_W]) >= s3_ff.den;
      s4_in.lre.rem = PROD_W'(s3_ff.mag_re[PROD_W-1:SHIFT_W]);
      s4_in.lre.nb  = {s3_ff.mag_re[SHIFT_W-1:0], {FRAC_W{1'b0}}};
      s4_in.lre.quo = '0;
      s4_in.lim.neg = s3_ff.neg_im;
      s4_in.lim.ovf = PROD_W'(s3_ff.mag_im[PROD_W-1:SHIFT_W]) >= s3_ff.den;
      s4_in.lim.rem = PROD_W'(s3_ff.mag_im[PROD_W-1:SHIFT_W]);
      s4_in.lim.nb  = {s3_ff.mag_im[SHIFT_W-1:0], {FRAC_W{1'b0}}};
      s4_in.lim.quo = '0;
   end

   // scaled product saturation, then the restoring divider stages
   always_comb begin
      sr = saturate(s4_ff.lre.neg, PROD_W'(s4_ff.m_re));
      si = saturate(s4_ff.lim.neg, PROD_W'(s4_ff.m_im));
      dst_in[0].ctl  = s4_ff.ctl;
      dst_in[0].pass = s4_ff.pass;
      dst_in[0].lre  = s4_ff.lre;
      dst_in[0].lim  = s4_ff.lim;
      dst_in[0].den  = s4_ff.den;
      if (s4_ff.ctl.op == OP_MUL || s4_ff.ctl.op == OP_MOD) begin
         dst_in[0].pass.re  = sr.value;
         dst_in[0].pass.im  = si.value;
         dst_in[0].pass.sat = sr.sat || si.sat;
      end
      for (int k = 1; k <= DIV_STEPS; k++) begin
         dst_in[k]     = dst_ff[k-1];
         dst_in[k].lre = div_step(dst_ff[k-1].lre, dst_ff[k-1].den);
         dst_in[k].lim = div_step(dst_ff[k-1].lim, dst_ff[k-1].den);
      end
   end

   // final selection and status
   always_comb begin
      dl = dst_ff[DIV_STEPS];
      qr = saturate(dl.lre.neg, dl.lre.ovf ? '1 : PROD_W'(dl.lre.quo));
      qi = saturate(dl.lim.neg, dl.lim.ovf ? '1 : PROD_W'(dl.lim.quo));
      fo_in.re = dl.pass.re;
      fo_in.im = dl.pass.im;
      fo_in.eq = dl.pass.eq;
      fo_in.st = dl.pass.sat ? ST_SAT : ST_OK;
      if (dl.ctl.div_zero) begin
         fo_in.st = ST_DIV_ZERO;
      end else if (dl.ctl.op == OP_DIV || dl.ctl.op == OP_SDIV) begin
         fo_in.re = qr.value;
         fo_in.im = qi.value;
         fo_in.st = (qr.sat || qi.sat) ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         v3_ff       <= 1'b0;
         v4_ff       <= 1'b0;
         dv_ff       <= '0;
         fo_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff       <= !q_empty;
         v2_ff       <= v1_ff;
         v3_ff       <= v2_ff;
         v4_ff       <= v3_ff;
         dv_ff       <= {dv_ff[DIV_STEPS-1:0], v4_ff};
         fo_valid_ff <= dv_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         dst_ff <= dst_in;
         fo_ff  <= fo_in;
      end
   end

   assign out_empty    = !fo_valid_ff;
   assign out_res_re   = fo_ff.re;
   assign out_res_im   = fo_ff.im;
   assign out_is_equal = fo_ff.eq;
   assign out_status   = fo_ff.st;

   `CAU_ASSERT_IMP(a_dz_zero, clock, reset, fo_valid_ff && fo_ff.st == ST_DIV_ZERO, fo_ff.re == '0 && fo_ff.im == '0)
   `CAU_ASSERT_IMP(a_eq_ok, clock, reset, fo_valid_ff && fo_ff.eq, fo_ff.st == ST_OK && fo_ff.re == '0)
   `CAU_ASSERT_NEXT(a_pipe_hold, clock, reset, v1_ff && !en, v1_ff && $stable(s1_ff))

endmodule

>>> rtl/complex_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// req       in         req_push / req_full  operation, a_re, a_im, b_re, b_im
// rsp       out        rsp_pop / rsp_empty  res_re, res_im, is_equal, status
// csr       in         csr_we               csr_wdata (equal tolerance)
//
// One item per cycle sustained while rsp is popped; a req transfer passes the front
// register, the queue and the 38-stage back pipe before rsp_empty drops. The back pipe
// length is set by the restoring divider, one quotient bit per stage over 32 stages,
// after the multiplier and sum stages.
// Reset empties front, queue and pipe and sets the tolerance to 655 (0.01).
// A stalled rsp freezes the back pipe; the 4-entry queue keeps the front taking items until it fills.
module complex_arithmetic_unit_core import cau_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [2:0]               req_operation,
   input  logic signed [DATA_W-1:0] req_a_re,
   input  logic signed [DATA_W-1:0] req_a_im,
   input  logic signed [DATA_W-1:0] req_b_re,
   input  logic signed [DATA_W-1:0] req_b_im,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic signed [DATA_W-1:0] rsp_res_re,
   output logic signed [DATA_W-1:0] rsp_res_im,
   output logic                     rsp_is_equal,
   output logic [1:0]               rsp_status,
   input  logic                     csr_we,
   input  logic [TOL_W-1:0]         csr_wdata
);

   logic [TOL_W-1:0] tol_ff;
   logic             q_push, q_full, q_pop, q_empty;
   item_type         q_in_item, q_out_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_we) begin
         tol_ff <= csr_wdata;
      end
   end

   cau_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_push      (req_push),
      .in_full      (req_full),
      .in_operation (req_operation),
      .in_a_re      (req_a_re),
      .in_a_im      (req_a_im),
      .in_b_re      (req_b_re),
      .in_b_im      (req_b_im),
      .q_push       (q_push),
      .q_item       (q_in_item),
      .q_full       (q_full)
   );

   cau_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (q_out_item)
   );

   cau_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_item       (q_out_item),
      .q_pop        (q_pop),
      .tolerance    (tol_ff),
      .out_empty    (rsp_empty),
      .out_pop      (rsp_pop),
      .out_res_re   (rsp_res_re),
      .out_res_im   (rsp_res_im),
      .out_is_equal (rsp_is_equal),
      .out_status   (rsp_status)
   );

endmodule

>>> tb/complex_arithmetic_unit_core_checker.sv
`timescale 1ns / 1ps
module complex_arithmetic_unit_core_checker import cau_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  logic                     req_full,
   input  logic [2:0]               req_operation,
   input  logic signed [DATA_W-1:0] req_a_re,
   input  logic signed [DATA_W-1:0] req_a_im,
   input  logic signed [DATA_W-1:0] req_b_re,
   input  logic signed [DATA_W-1:0] req_b_im,
   input  logic                     rsp_empty,
   input  logic                     rsp_pop,
   input  logic signed [DATA_W-1:0] rsp_res_re,
   input  logic signed [DATA_W-1:0] rsp_res_im,
   input  logic                     rsp_is_equal,
   input  logic [1:0]               rsp_status,
   input  logic                     csr_we,
   input  logic [TOL_W-1:0]         csr_wdata,
   output int                       errors,
   output int                       pending
);

   typedef struct {
      logic [31:0] re;
      logic [31:0] im;
      logic        eq;
      logic [1:0]  st;
   } answer_type;

   localparam logic [63:0] HALF = 64'h8000_0000_0000_0000;

   answer_type       answers[$];
   logic [TOL_W-1:0] tolerance;

   function automatic logic [31:0] clamp(input bit neg, input logic [63:0] mag, inout bit sat);
      logic [63:0] lim;
      logic [63:0] v;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (mag > lim) begin
         mag = lim;
         sat = 1;
      end
      v = neg ? -mag : mag;
      return v[31:0];
   endfunction

   // product back to Q16.16, floor rounding
   function automatic logic [31:0] rescale(input bit neg, input logic [63:0] mag, inout bit sat);
      logic [63:0] m;
      m = neg ? (mag + 64'hFFFF) >> FRAC_W : mag >> FRAC_W;
      if (m == 0) neg = 0;
      return clamp(neg, m, sat);
   endfunction

   function automatic logic [31:0] quotient(input bit neg, input logic [63:0] num,
                                            input logic [63:0] den, inout bit sat);
      logic [63:0] lim;
      logic [63:0] q;
      logic [63:0] r;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      q = num / den;
      r = num % den;
      if (q > (lim >> FRAC_W)) return clamp(neg, lim + 1, sat);
      for (int i = 0; i < FRAC_W; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q[0] = 1'b1;
         end
      end
      if (q == 0) neg = 0;
      return clamp(neg, q, sat);
   endfunction

   function automatic answer_type solve_item(input op_type op, input longint ar,
                                             input longint ai, input longint br,
                                             input longint bi,
                                             input logic [TOL_W-1:0] tol);
      answer_type  a;
      bit          sat;
      bit          neg;
      bit          dneg;
      logic [63:0] u;
      logic [63:0] den;
      longint      d;
      logic [63:0] dr;
      logic [63:0] di;
      a = '{re: '0, im: '0, eq: 1'b0, st: ST_OK};
      sat = 0;
      case (op)
         OP_ADD, OP_SUB: begin
            d = (op == OP_ADD) ? ar + br : ar - br;
            a.re = clamp(d < 0, d < 0 ? -d : d, sat);
            d = (op == OP_ADD) ? ai + bi : ai - bi;
            a.im = clamp(d < 0, d < 0 ? -d : d, sat);
         end
         OP_MUL: begin
            u = 64'(ar * br) - 64'(ai * bi);
            neg = u > HALF;
            a.re = rescale(neg, neg ? -u : u, sat);
            u = 64'(ar * bi) + 64'(ai * br);
            neg = u > HALF;
            a.im = rescale(neg, neg ? -u : u, sat);
         end
         OP_DIV: begin
            if (br == 0 && bi == 0) a.st = ST_DIV_ZERO;
            else begin
               den = 64'(br * br) + 64'(bi * bi);
               u = 64'(ar * br) + 64'(ai * bi);
               neg = u > HALF;
               a.re = quotient(neg, neg ? -u : u, den, sat);
               u = 64'(ai * br) - 64'(ar * bi);
               neg = u > HALF;
               a.im = quotient(neg, neg ? -u : u, den, sat);
            end
         end
         OP_SDIV: begin
            if (br == 0) a.st = ST_DIV_ZERO;
            else begin
               dneg = br < 0;
               den = dneg ? -br : br;
               a.re = quotient((ar < 0) != dneg, ar < 0 ? -ar : ar, den, sat);
               a.im = quotient((ai < 0) != dneg, ai < 0 ? -ai : ai, den, sat);
            end
         end
         OP_CONJ: begin
            a.re = ar[31:0];
            a.im = clamp(ai > 0, ai > 0 ? ai : -ai, sat);
         end
         OP_MOD: a.re = rescale(0, 64'(ar * ar) + 64'(ai * ai), sat);
         default: begin
            d = ar - br;
            dr = d < 0 ? -d : d;
            d = ai - bi;
            di = d < 0 ? -d : d;
            a.eq = dr <= tol && di <= tol;
         end
      endcase
      if (a.st == ST_OK && sat) a.st = ST_SAT;
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         tolerance <= TOL_RESET;
         errors <= 0;
         answers.delete();
      end else begin
         if (csr_we) tolerance <= csr_wdata;
         if (req_push && !req_full)
            answers.push_back(solve_item(op_type'(req_operation), req_a_re, req_a_im,
                                         req_b_re, req_b_im, tolerance));
         if (rsp_pop && !rsp_empty) begin
            if (answers.size() == 0) begin
               $display("%0t: transfer with nothing outstanding: re %h im %h eq %b st %0d",
                        $time, rsp_res_re, rsp_res_im, rsp_is_equal, rsp_status);
               errors <= errors + 1;
            end else begin
               want = answers.pop_front();
               if (rsp_res_re !== want.re || rsp_res_im !== want.im ||
                   rsp_is_equal !== want.eq || rsp_status !== want.st) begin
                  $display("%0t: mismatch expected re %h im %h eq %b st %0d, got re %h im %h eq %b st %0d",
                           $time, want.re, want.im, want.eq, want.st,
                           rsp_res_re, rsp_res_im, rsp_is_equal, rsp_status);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

   assign pending = answers.size();

endmodule

>>> tb/complex_arithmetic_unit_core_test.sv
`timescale 1ns / 1ps
module complex_arithmetic_unit_core_test;
   import cau_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 250;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [2:0]  req_operation;
   word_type    req_a_re, req_a_im, req_b_re, req_b_im;
   logic        rsp_empty;
   logic        rsp_pop;
   word_type    rsp_res_re, rsp_res_im;
   logic        rsp_is_equal;
   logic [1:0]  rsp_status;
   logic        csr_we;
   logic [TOL_W-1:0] csr_wdata;
   int          errors, pending;

   int          tx_idle, rx_idle;
   logic        hold_req;
   bit          hold_used;
   int          hold_left;
   int          stall;

   complex_arithmetic_unit_core dut (.*);

   complex_arithmetic_unit_core_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // receiver; one long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_pop <= 0;
      end else if (hold_req && !hold_used) begin
         hold_used = 1;
         hold_left = HOLD_CYCLES;
         rsp_pop <= 0;
      end else begin
         rsp_pop <= $urandom_range(99) >= rx_idle;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) stall <= 0;
      else stall <= stall + 1;
      if (stall >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send_item(input op_type op, input word_type ar, input word_type ai,
                            input word_type br, input word_type bi);
      if ($urandom_range(99) < tx_idle) begin
         req_push <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_push <= 1;
      req_operation <= op;
      req_a_re <= ar;
      req_a_im <= ai;
      req_b_re <= br;
      req_b_im <= bi;
      do @(negedge clock); while (req_full);
      @(posedge clock);
   endtask

   // sender pause until every outstanding result is back, then pipe settle
   task automatic drain();
      req_push <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [TOL_W-1:0] v);
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
   endtask

   function automatic word_type pick_word();
      case ($urandom_range(9))
         0, 1, 2: return word_type'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
         3:       return word_type'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
         4, 5, 6: return word_type'($urandom);
         7: case ($urandom_range(5))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return -32'sd1;
               3: return 32'sd1;
               4: return 32'sh0001_0000;
               default: return -32'sh0001_0000;
            endcase
         8: return word_type'($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
         default: return 0;
      endcase
   endfunction

   task automatic random_items(input int count);
      op_type   op;
      word_type ar, ai, br, bi;
      for (int n = 0; n < count; n++) begin
         op = op_type'($urandom_range(7));
         ar = pick_word();
         ai = pick_word();
         br = pick_word();
         bi = pick_word();
         if (op == OP_EQUAL && $urandom_range(1)) begin
            br = ar + word_type'($urandom_range(0, 2000)) - 1000;
            bi = ai + word_type'($urandom_range(0, 2000)) - 1000;
         end
         send_item(op, ar, ai, br, bi);
      end
   endtask

   task automatic directed_items();
      send_item(OP_ADD, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd1, -32'sd1);
      send_item(OP_ADD, 32'sh0001_8000, -32'sh0000_4000, 32'sh0002_0000, 32'sh0000_4000);
      send_item(OP_SUB, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1, -32'sd1);
      send_item(OP_SUB, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_item(OP_MUL, 32'sh0002_0000, 32'sh0003_0000, -32'sh0001_0000, 32'sh0000_8000);
      send_item(OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_item(OP_MUL, -32'sd1, 32'sd1, 32'sd1, 32'sd1);
      send_item(OP_MUL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -32'sh7FFF_FFFF);
      send_item(OP_DIV, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, -32'sh0001_0000);
      send_item(OP_DIV, 32'sh1234_5678, 32'sh0BAD_F00D, 0, 0);
      send_item(OP_DIV, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sd1, 0);
      send_item(OP_DIV, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_item(OP_SDIV, 32'sh0005_0000, -32'sh0003_0000, -32'sh0002_0000, 32'sh1111_1111);
      send_item(OP_SDIV, 32'sh0005_0000, 32'sh0003_0000, 0, 32'sh0001_0000);
      send_item(OP_SDIV, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 0);
      send_item(OP_SDIV, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 0);
      send_item(OP_CONJ, 32'sh0001_0000, 32'sh8000_0000, 32'sh5555_5555, -32'sd7);
      send_item(OP_CONJ, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0);
      send_item(OP_MOD, 32'sh8000_0000, 32'sh8000_0000, -32'sd9, 32'sd9);
      send_item(OP_MOD, 32'sh0003_0000, -32'sh0004_0000, 0, 0);
      send_item(OP_MOD, -32'sd1, 32'sd1, 0, 0);
      send_item(OP_EQUAL, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_028F, 32'sh0000_FD71);
      send_item(OP_EQUAL, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0290, 32'sh0001_0000);
      send_item(OP_EQUAL, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
   endtask

   initial begin
      reset = 1;
      req_push = 0;
      req_operation = '0;
      req_a_re = 0;
      req_a_im = 0;
      req_b_re = 0;
      req_b_im = 0;
      csr_we = 0;
      csr_wdata = '0;
      hold_req = 0;
      hold_used = 0;
      hold_left = 0;
      tx_idle = 13;
      rx_idle = 48;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      directed_items();
      random_items(60);
      hold_req <= 1;     // receiver stops while the sender keeps offering
      random_items(100);
      drain();

      write_tolerance('0);
      tx_idle = 48;
      rx_idle = 13;
      random_items(160);
      drain();

      write_tolerance({TOL_W{1'b1}});
      tx_idle = 0;
      rx_idle = 0;
      random_items(160);
      drain();

      write_tolerance(TOL_W'($urandom_range(0, 5000)));
      tx_idle = 13;
      rx_idle = 48;
      random_items(170);

      drain();
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_queue.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit_core.sv
tb/complex_arithmetic_unit_core_checker.sv
tb/complex_arithmetic_unit_core_test.sv
